// ===== src/lfu_cache_lru_tiebreak_defines.svh =====
// shared assertion macros
`ifndef LFU_CACHE_LRU_TIEBREAK_DEFINES_SVH
`define LFU_CACHE_LRU_TIEBREAK_DEFINES_SVH

// property checked on every rising edge, quiet while in reset
`define LFUC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge, reset included
`define LFUC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/lfuc_pkg.sv =====
package lfuc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CAP_W   = 5;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int USE_W   = 32;
  localparam int RANK_W  = IDX_W;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // one cache line as held in the entry memory
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [USE_W-1:0]  count;
    logic [RANK_W-1:0] rank;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // outcome of one sweep over the entries
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] hit_idx;
    entry_t           hit_entry;
    logic             have_victim;
    logic [IDX_W-1:0] vic_idx;
    entry_t           vic_entry;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } scan_res_t;

endpackage

// ===== src/lfuc_ram.sv =====
module lfuc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/lfuc_scan.sv =====
module lfuc_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       rd_vld,
  input  logic [lfuc_pkg::IDX_W-1:0] rd_idx,
  input  lfuc_pkg::entry_t           rd_data,
  input  logic                       rd_valid_bit,
  input  logic [lfuc_pkg::KEY_W-1:0] key,
  output lfuc_pkg::scan_res_t        res
);

  logic match;
  logic better;

  // key compare and victim order: lower count first, then least recent
  always_comb begin
    match  = rd_valid_bit && (rd_data.key == key);
    better = rd_valid_bit && (!res.have_victim ||
             (rd_data.count < res.vic_entry.count) ||
             ((rd_data.count == res.vic_entry.count) &&
              (rd_data.rank > res.vic_entry.rank)));
  end

  // accumulate as the entries stream past, lowest index first
  always_ff @(posedge clk) begin
    if (rst || start) begin
      res.found       <= 1'b0;
      res.have_victim <= 1'b0;
      res.free_found  <= 1'b0;
      res.hit_idx     <= '0;
      res.vic_idx     <= '0;
      res.free_idx    <= '0;
    end else if (rd_vld) begin
      if (match && !res.found) begin
        res.found     <= 1'b1;
        res.hit_idx   <= rd_idx;
        res.hit_entry <= rd_data;
      end
      if (better) begin
        res.have_victim <= 1'b1;
        res.vic_idx     <= rd_idx;
        res.vic_entry   <= rd_data;
      end
      if (!rd_valid_bit && !res.free_found) begin
        res.free_found <= 1'b1;
        res.free_idx   <= rd_idx;
      end
    end
  end

endmodule

// ===== src/lfu_cache_lru_tiebreak.sv =====
// LFU key-value cache, fully associative, 16 entries, with ties among equal
// use counts broken by least recent use. Entries live in one memory with a
// registered read, so each operation is two sweeps over it: a lookup sweep
// (key match, victim and free slot search, 16 reads, then a drain state)
// and, unless the operation is a get miss, a read-modify-write sweep that
// shifts the recency ranks and writes the chosen entry. The entry memory
// has a single read port. Items are handled one at a time; the result sits
// in an output register and the block only waits on it when the next
// result is ready. capacity_in_use must be written through the cfg port
// only while the block is idle; the block itself does not enforce this.
// 0 counts as 1 and values above 16 as 16.
`include "lfu_cache_lru_tiebreak_defines.svh"

module lfu_cache_lru_tiebreak (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write: capacity_in_use
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lfuc_pkg::CAP_W-1:0] cfg_data,
  // requests
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [63:0]                s_tdata,   // lookup_key, write_value
  input  logic [0:0]                 s_tuser,   // operation
  // results
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [63:0]                m_tdata,   // read_value, evicted_key
  output logic [1:0]                 m_tuser    // hit, evicted
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_SLAST  = 6'b000100,
    ST_DECIDE = 6'b001000,
    ST_UPD    = 6'b010000,
    ST_ULAST  = 6'b100000
  } state_t;

  state_t state;

  logic [lfuc_pkg::CAP_W-1:0]  capacity;
  logic [lfuc_pkg::CAP_W-1:0]  cap_eff;
  logic [lfuc_pkg::CAP_W-1:0]  occupied;
  logic [lfuc_pkg::ENTRIES-1:0] valid;

  logic [lfuc_pkg::IDX_W-1:0]  idx;
  logic                        pend;
  logic [lfuc_pkg::IDX_W-1:0]  pend_idx;

  logic                        req_op;
  logic [lfuc_pkg::KEY_W-1:0]  req_key;
  logic [lfuc_pkg::VAL_W-1:0]  req_val;

  logic [lfuc_pkg::IDX_W-1:0]  slot;
  logic                        ins;
  logic [lfuc_pkg::RANK_W-1:0] old_rank;
  lfuc_pkg::entry_t            new_rec;

  logic                        out_hit;
  logic                        out_ev;
  logic [lfuc_pkg::VAL_W-1:0]  out_rd;
  logic [lfuc_pkg::KEY_W-1:0]  out_evk;

  lfuc_pkg::entry_t            rd_data;
  lfuc_pkg::entry_t            wr_data;
  logic                        wr_en;
  lfuc_pkg::scan_res_t         scan;

  logic in_xfer;
  logic out_free;
  logic in_upd;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign in_upd    = pend && ((state == ST_UPD) || (state == ST_ULAST));

  assign m_tdata = {out_evk, out_rd};
  assign m_tuser = {out_ev, out_hit};

  // effective capacity
  always_comb begin
    if (capacity == '0) begin
      cap_eff = lfuc_pkg::CAP_W'(1);
    end else if (capacity > lfuc_pkg::CAP_W'(lfuc_pkg::ENTRIES)) begin
      cap_eff = lfuc_pkg::CAP_W'(lfuc_pkg::ENTRIES);
    end else begin
      cap_eff = capacity;
    end
  end

  // entry memory
  lfuc_ram #(
    .WIDTH (lfuc_pkg::ENTRY_W),
    .DEPTH (lfuc_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (pend_idx),
    .wdata (wr_data),
    .raddr (idx),
    .rdata (rd_data)
  );

  // lookup sweep
  lfuc_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .start        (in_xfer),
    .rd_vld       (pend && ((state == ST_SCAN) || (state == ST_SLAST))),
    .rd_idx       (pend_idx),
    .rd_data      (rd_data),
    .rd_valid_bit (valid[pend_idx]),
    .key          (req_key),
    .res          (scan)
  );

  // write-back: chosen entry, or a rank shift for more recent entries (all valid ones on an insertion)
  always_comb begin
    wr_en   = 1'b0;
    wr_data = rd_data;
    if (in_upd) begin
      if (pend_idx == slot) begin
        wr_en   = 1'b1;
        wr_data = new_rec;
      end else if (valid[pend_idx] && (ins || (rd_data.rank < old_rank))) begin
        wr_en        = 1'b1;
        wr_data.rank = rd_data.rank + lfuc_pkg::RANK_W'(1);
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfuc_pkg::CAP_W'(lfuc_pkg::ENTRIES);
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // sweep address and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      idx  <= '0;
    end else begin
      pend <= (state == ST_SCAN) || (state == ST_UPD);
      if ((state == ST_SCAN) || (state == ST_UPD)) begin
        idx <= idx + lfuc_pkg::IDX_W'(1);
      end else begin
        idx <= '0;
      end
    end
    pend_idx <= idx;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_op  <= s_tuser[0];
      req_key <= s_tdata[31:0];
      req_val <= s_tdata[63:32];
    end
  end

  // sequencer, decision and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      valid    <= '0;
      occupied <= '0;
      m_tvalid <= 1'b0;
      ins      <= 1'b0;
      slot     <= '0;
    end else begin
      if ((state == ST_DECIDE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx == lfuc_pkg::IDX_W'(lfuc_pkg::ENTRIES - 1)) begin
            state <= ST_SLAST;
          end
        end
        ST_SLAST: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_hit      <= scan.found;
            new_rec.key  <= req_key;
            new_rec.rank <= '0;
            if (scan.found) begin
              slot     <= scan.hit_idx;
              old_rank <= scan.hit_entry.rank;
              ins      <= 1'b0;
              out_ev   <= 1'b0;
              out_evk  <= '0;
              if (req_op == lfuc_pkg::OP_GET) begin
                out_rd        <= scan.hit_entry.value;
                new_rec.value <= scan.hit_entry.value;
              end else begin
                out_rd        <= '1;
                new_rec.value <= req_val;
              end
              if (scan.hit_entry.count != '1) begin
                new_rec.count <= scan.hit_entry.count + lfuc_pkg::USE_W'(1);
              end else begin
                new_rec.count <= scan.hit_entry.count;
              end
              state <= ST_UPD;
            end else begin
              out_rd        <= '1;
              new_rec.value <= req_val;
              new_rec.count <= lfuc_pkg::USE_W'(1);
              if (req_op == lfuc_pkg::OP_PUT) begin
                if (occupied >= cap_eff) begin
                  slot     <= scan.vic_idx;
                  old_rank <= scan.vic_entry.rank;
                  ins      <= 1'b0;
                  out_ev   <= scan.have_victim;
                  out_evk  <= scan.have_victim ? scan.vic_entry.key : '0;
                end else begin
                  slot                 <= scan.free_idx;
                  ins                  <= 1'b1;
                  old_rank             <= '0;
                  out_ev               <= 1'b0;
                  out_evk              <= '0;
                  valid[scan.free_idx] <= 1'b1;
                  occupied             <= occupied + lfuc_pkg::CAP_W'(1);
                end
                state <= ST_UPD;
              end else begin
                ins     <= 1'b0;
                out_ev  <= 1'b0;
                out_evk <= '0;
                state   <= ST_IDLE;
              end
            end
          end
        end
        ST_UPD: begin
          if (idx == lfuc_pkg::IDX_W'(lfuc_pkg::ENTRIES - 1)) begin
            state <= ST_ULAST;
          end
        end
        ST_ULAST: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // occupancy tracks the valid marks
  `LFUC_ASSERT(a_occ_matches_valid, ($countones(valid) == occupied), "occupancy mismatch")
  // write-back never lands on the address being read
  `LFUC_ASSERT(a_no_rw_overlap, (wr_en |-> (pend_idx != idx)), "read/write overlap")
  // an insertion always finds a free slot
  `LFUC_ASSERT(a_free_on_insert,
    ((state == ST_DECIDE) && out_free && !scan.found && (req_op == lfuc_pkg::OP_PUT) &&
     (occupied < cap_eff) |-> scan.free_found), "insert without free slot")

endmodule

// ===== test/lfu_cache_lru_tiebreak_tb.sv =====
`timescale 1ns / 100ps

module lfu_cache_lru_tiebreak_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  // expected outcome of one cache operation
  typedef struct {
    logic                       hit;
    logic [lfuc_pkg::VAL_W-1:0] read_value;
    logic                       evicted;
    logic [lfuc_pkg::KEY_W-1:0] evicted_key;
  } outcome_t;

  // software copy of the cache plus the queue of pending outcomes
  class cache_scoreboard;
    logic [lfuc_pkg::CAP_W-1:0]  capacity;
    logic                        line_valid [lfuc_pkg::ENTRIES];
    logic [lfuc_pkg::KEY_W-1:0]  line_key [lfuc_pkg::ENTRIES];
    logic [lfuc_pkg::VAL_W-1:0]  line_value [lfuc_pkg::ENTRIES];
    logic [lfuc_pkg::USE_W-1:0]  line_count [lfuc_pkg::ENTRIES];
    logic [lfuc_pkg::RANK_W:0]   line_rank [lfuc_pkg::ENTRIES];
    int unsigned                 occupancy;
    outcome_t                    pending[$];
    int unsigned                 mismatches;
    int unsigned                 checked;
    int unsigned                 hits;
    int unsigned                 evictions;

    function new();
      capacity = lfuc_pkg::CAP_W'(lfuc_pkg::ENTRIES);
      occupancy = 0;
      mismatches = 0;
      checked = 0;
      hits = 0;
      evictions = 0;
      for (int i = 0; i < lfuc_pkg::ENTRIES; i++) begin
        line_valid[i] = 1'b0;
        line_rank[i] = '0;
        line_count[i] = '0;
      end
    endfunction

    // make slot s most recent, shifting the valid lines ranked below old_rank
    function void promote(int s, int unsigned old_rank);
      for (int i = 0; i < lfuc_pkg::ENTRIES; i++)
        if (i != s && line_valid[i] && line_rank[i] < old_rank)
          line_rank[i] = line_rank[i] + 1'b1;
      line_rank[s] = '0;
    endfunction

    // apply one accepted request and queue its outcome
    function void note_request(logic op, logic [lfuc_pkg::KEY_W-1:0] key,
                               logic [lfuc_pkg::VAL_W-1:0] value);
      outcome_t o;
      int unsigned cap;
      int slot;
      bit found;
      bit have;
      o.hit = 1'b0;
      o.read_value = '1;
      o.evicted = 1'b0;
      o.evicted_key = '0;
      cap = 32'(capacity);
      found = 0;
      slot = 0;
      have = 0;
      if (cap == 0) cap = 1;
      if (cap > lfuc_pkg::ENTRIES) cap = lfuc_pkg::ENTRIES;
      for (int i = 0; i < lfuc_pkg::ENTRIES; i++)
        if (!found && line_valid[i] && line_key[i] == key) begin
          found = 1;
          slot = i;
        end
      if (found) begin
        o.hit = 1'b1;
        if (op == lfuc_pkg::OP_GET) o.read_value = line_value[slot];
        else line_value[slot] = value;
        if (line_count[slot] != '1) line_count[slot] = line_count[slot] + 1'b1;
        promote(slot, 32'(line_rank[slot]));
      end else if (op == lfuc_pkg::OP_PUT) begin
        if (occupancy >= cap) begin
          // victim: lowest count, then least recent
          for (int i = 0; i < lfuc_pkg::ENTRIES; i++) begin
            if (!line_valid[i]) continue;
            if (!have || line_count[i] < line_count[slot] ||
                (line_count[i] == line_count[slot] &&
                 line_rank[i] > line_rank[slot])) begin
              have = 1;
              slot = i;
            end
          end
          if (have) begin
            o.evicted = 1'b1;
            o.evicted_key = line_key[slot];
            promote(slot, 32'(line_rank[slot]));
          end
        end else begin
          for (int i = lfuc_pkg::ENTRIES - 1; i >= 0; i--)
            if (!line_valid[i]) slot = i;
          line_valid[slot] = 1'b1;
          occupancy++;
          promote(slot, 32'hFFFF_FFFF);
        end
        line_key[slot] = key;
        line_value[slot] = value;
        line_count[slot] = lfuc_pkg::USE_W'(1);
      end
      pending.push_back(o);
    endfunction

    // compare one accepted result with the oldest pending outcome
    function void check_result(logic [63:0] data, logic [1:0] user);
      outcome_t o;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tdata=%h tuser=%b", data, user);
        return;
      end
      o = pending.pop_front();
      checked++;
      if (o.hit) hits++;
      if (o.evicted) evictions++;
      if (user[0] !== o.hit || data[31:0] !== o.read_value ||
          user[1] !== o.evicted || data[63:32] !== o.evicted_key) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result %0d: exp hit=%b val=%h ev=%b evk=%h, ",
                    "got hit=%b val=%h ev=%b evk=%h"},
                   checked, o.hit, o.read_value, o.evicted, o.evicted_key,
                   user[0], data[31:0], user[1], data[63:32]);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [lfuc_pkg::CAP_W-1:0] cfg_data;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [63:0]                s_tdata;   // lookup_key, write_value
  logic [0:0]                 s_tuser;   // operation
  logic                       m_tvalid;
  logic                       m_tready;
  logic [63:0]                m_tdata;   // read_value, evicted_key
  logic [1:0]                 m_tuser;   // hit, evicted

  cache_scoreboard            cache_model;
  int unsigned                send_idle_pct;
  int unsigned                recv_stall_pct;
  int unsigned                quiet_cycles;
  int unsigned                requests_sent;
  logic [lfuc_pkg::KEY_W-1:0] key_pool [8];

  lfu_cache_lru_tiebreak uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side: random stalls, check on each transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) cache_model.check_result(m_tdata, m_tuser);
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("lfu_cache_lru_tiebreak: mismatch");
      $finish;
    end
  end

  // one request transfer, with an optional random gap first
  task automatic send_request(logic op, logic [lfuc_pkg::KEY_W-1:0] key,
                              logic [lfuc_pkg::VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {value, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cache_model.note_request(op, key, value);
    requests_sent++;
  endtask

  // wait for all results, then let the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (cache_model.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write capacity_in_use while idle
  task automatic set_capacity(logic [lfuc_pkg::CAP_W-1:0] cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cache_model.capacity = cap;
  endtask

  // mostly keys from a small pool so hits, count ties and evictions occur
  task automatic random_requests(int n);
    logic [lfuc_pkg::KEY_W-1:0] key;
    logic op;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) key = key_pool[$urandom_range(7)];
      else key = $urandom;
      op = 1'($urandom_range(1));
      send_request(op, key, $urandom);
    end
  endtask

  initial begin
    logic [lfuc_pkg::CAP_W-1:0] caps [6];
    cache_model = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    requests_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes of keys and values, get/put hit and miss, tie break
    send_request(lfuc_pkg::OP_GET, 32'h0, 32'h0);
    send_request(lfuc_pkg::OP_PUT, 32'h0, 32'h8000_0000);
    send_request(lfuc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(lfuc_pkg::OP_GET, 32'h0, 32'h0);
    send_request(lfuc_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lfuc_pkg::OP_PUT, 32'h0, 32'hFFFF_FFFF);
    send_request(lfuc_pkg::OP_GET, 32'h0, 32'h0);
    set_capacity(5'd1);
    send_request(lfuc_pkg::OP_PUT, 32'h1234_5678, 32'h1);
    send_request(lfuc_pkg::OP_PUT, 32'hA5A5_A5A5, 32'h2);
    send_request(lfuc_pkg::OP_GET, 32'hA5A5_A5A5, 32'h0);
    // capacity zero behaves as one, values above the built size as full size
    set_capacity(5'd0);
    send_request(lfuc_pkg::OP_PUT, 32'h5A5A_5A5A, 32'h3);
    set_capacity(5'd31);
    for (int i = 0; i < 10; i++) send_request(lfuc_pkg::OP_PUT, 32'h100 + i, i);
    set_capacity(5'd2);
    send_request(lfuc_pkg::OP_PUT, 32'hDEAD_BEEF, 32'h4);
    send_request(lfuc_pkg::OP_PUT, 32'hCAFE_F00D, 32'h5);

    // random phases over capacities and handshake pressure
    caps = '{5'd16, 5'd1, 5'd4, 5'd8, 5'd3, 5'd16};
    for (int ph = 0; ph < 4 * 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      if (ph % 4 == 0) begin
        set_capacity(caps[ph / 4]);
        for (int k = 0; k < 8; k++) key_pool[k] = (k < 2) ? {32{k[0]}} : $urandom;
      end
      random_requests(42);
    end

    drain();
    $display("%0d requests, %0d results checked, %0d hits, %0d evictions",
             requests_sent, cache_model.checked, cache_model.hits,
             cache_model.evictions);
    $display("capacities 0, 1, 2, 3, 4, 8, 16 and 31 were exercised");
    if (cache_model.mismatches == 0)
      $display("lfu_cache_lru_tiebreak: match");
    else
      $display("lfu_cache_lru_tiebreak: mismatch");
    $finish;
  end

endmodule
